// ----- rtl/core/preroll_slice_capture_controller_defines.svh -----
// Assertion macros for the pre-roll slice capture controller.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PREROLL_SLICE_CAPTURE_CONTROLLER_DEFINES_SVH
`define PREROLL_SLICE_CAPTURE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define PSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/psc_pkg.sv -----
// Shared types, constants and codes of the pre-roll slice capture controller.
// No dependencies.
package psc_pkg;

  localparam int PAD_COUNT   = 16;
  localparam int PAD_W       = 4;
  localparam int NPAD_W      = 5;
  localparam int MAX_FRAMES  = 65536;
  localparam int POS_W       = 17;
  localparam int RING_FRAMES = 4096;
  localparam int RING_AW     = 12;
  localparam int FILL_W      = 13;
  localparam int SAMPLE_BITS = 24;
  localparam int SQ_W        = 48;
  localparam int SUM_W       = 64;
  localparam int OSUM_W      = 63;

  // Input kinds
  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_NOTE    = 3'd1;
  localparam logic [2:0] KIND_FINAL   = 3'd2;
  localparam logic [2:0] KIND_UNDO    = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  // Internal operation codes
  localparam logic [2:0] OP_FRAME   = 3'd0;
  localparam logic [2:0] OP_NOTE    = 3'd1;
  localparam logic [2:0] OP_FINAL   = 3'd2;
  localparam logic [2:0] OP_UNDO    = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  // Result event codes
  localparam logic [1:0] EV_COMMIT  = 2'd0;
  localparam logic [1:0] EV_CLEARED = 2'd1;
  localparam logic [1:0] EV_SESSION = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ARMED     = 3'd0;
  localparam logic [2:0] CFG_MODE      = 3'd1;
  localparam logic [2:0] CFG_START_PAD = 3'd2;
  localparam logic [2:0] CFG_PREROLL   = 3'd3;
  localparam logic [2:0] CFG_FIXED_LEN = 3'd4;

  typedef struct packed {
    logic [2:0]                    op;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } psc_item_t;

  typedef struct packed {
    logic              armed;
    logic              mode;
    logic [PAD_W-1:0]  start_pad;
    logic [12:0]       preroll;
    logic [POS_W-1:0]  fixed_len;
  } psc_cfg_t;

  typedef struct packed {
    logic              active;
    logic              session_complete;
    logic [NPAD_W-1:0] next_pad;
  } psc_status_t;

  typedef struct packed {
    logic [1:0]             code;
    logic [PAD_W-1:0]       pad;
    logic [POS_W-1:0]       frames;
    logic [SAMPLE_BITS-1:0] peak;
    logic [OSUM_W-1:0]      sum;
    logic                   done;
  } psc_result_t;

endpackage

// ----- rtl/core/psc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/psc_front.sv -----
// Front end: accepts input transactions, classifies the kind and queues them.
// Depends on psc_pkg.
module psc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          in_kind,
  input  logic [47:0]         in_samples,
  output logic                item_valid,
  output psc_pkg::psc_item_t  item,
  input  logic                item_pop
);
  import psc_pkg::*;

  psc_item_t   q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        known;
  logic [2:0]  op;
  logic        push;

  always_comb begin
    known = 1'b1;
    op    = OP_FRAME;
    case (in_kind)
      KIND_FRAME:   op = OP_FRAME;
      KIND_NOTE:    op = OP_NOTE;
      KIND_FINAL:   op = OP_FINAL;
      KIND_UNDO:    op = OP_UNDO;
      KIND_RESTART: op = OP_RESTART;
      default:      known = 1'b0;
    endcase
  end

  assign in_tready  = (cnt_r != 2'd2);
  // drop unknown kinds here
  assign push       = in_tvalid && in_tready && known;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ item_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op, left: in_samples[23:0], right: in_samples[47:24]};
    end
  end

endmodule

// ----- rtl/core/psc_back.sv -----
// Back end: pre-roll ring, slice state, statistics walks and result register.
// Depends on psc_pkg and psc_ram.
module psc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psc_pkg::psc_cfg_t    cfg,
  input  logic                 item_valid,
  input  psc_pkg::psc_item_t   item,
  output logic                 item_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psc_pkg::psc_result_t out_res,
  output psc_pkg::psc_status_t status
);
  import psc_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_FRM_WAIT = 4'd1;
  localparam logic [3:0] ST_FRM_END  = 4'd2;
  localparam logic [3:0] ST_TRIM     = 4'd3;
  localparam logic [3:0] ST_COMMIT   = 4'd4;
  localparam logic [3:0] ST_BEGIN    = 4'd5;
  localparam logic [3:0] ST_PRE      = 4'd6;

  logic [3:0]              state_r, state_nxt;
  logic [RING_AW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic                    active_r, active_nxt;
  logic [PAD_W-1:0]        active_pad_r, active_pad_nxt;
  logic                    last_valid_r, last_valid_nxt;
  logic [PAD_W-1:0]        last_pad_r, last_pad_nxt;
  logic [NPAD_W-1:0]       next_pad_r, next_pad_nxt;
  logic                    sc_r, sc_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [SAMPLE_BITS-1:0]  peak_r, peak_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    note_r, note_nxt;
  logic                    has_res_r, has_res_nxt;
  psc_result_t             res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  psc_result_t             out_res_r, out_res_nxt;

  logic [RING_AW-1:0]      walk_addr_r, walk_addr_nxt;
  logic [FILL_W-1:0]       walk_left_r, walk_left_nxt;
  logic                    walk_sub_r, walk_sub_nxt;
  logic                    rd_v_r;
  logic                    mul_v_r, mul_sub_r;
  logic [SQ_W-1:0]         sql_r, sqr_r;
  logic [SAMPLE_BITS-1:0]  peakc_r;

  logic                    ram_we, ram_re;
  logic [47:0]             ram_rdata;
  logic                    frm_issue;
  logic                    pipe_busy;
  logic [SAMPLE_BITS-1:0]  src_l, src_r, mag_l, mag_r;
  logic [SUM_W-1:0]        sq_pair;
  logic [SUM_W:0]          sum_add;
  logic [FILL_W-1:0]       pre_eff, pre_cnt;
  logic [POS_W-1:0]        trim, limit;
  logic                    go;
  logic                    sc_tmp;

  psc_ram #(.WIDTH(48), .DEPTH(RING_FRAMES)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata ({item.right, item.left}),
    .re    (ram_re),
    .raddr (walk_addr_r),
    .rdata (ram_rdata)
  );

  // Derived limits
  always_comb begin
    pre_eff = (cfg.preroll > FILL_W'(RING_FRAMES)) ? FILL_W'(RING_FRAMES) : cfg.preroll;
    pre_cnt = (pre_eff < fill_r) ? pre_eff : fill_r;
    trim    = ({4'd0, pre_eff} < pos_r) ? {4'd0, pre_eff} : pos_r;
    if (!cfg.mode) begin
      limit = POS_W'(MAX_FRAMES);
    end else if (cfg.fixed_len == '0) begin
      limit = POS_W'(1);
    end else if (cfg.fixed_len > POS_W'(MAX_FRAMES)) begin
      limit = POS_W'(MAX_FRAMES);
    end else begin
      limit = cfg.fixed_len;
    end
    go = cfg.armed && (cfg.mode ? !sc_r : (active_r || !sc_r));
  end

  // Square stage source: ring read data during walks, else the incoming frame
  always_comb begin
    src_l = rd_v_r ? ram_rdata[23:0]  : item.left;
    src_r = rd_v_r ? ram_rdata[47:24] : item.right;
    mag_l = src_l[SAMPLE_BITS-1] ? (~src_l + 1'b1) : src_l;
    mag_r = src_r[SAMPLE_BITS-1] ? (~src_r + 1'b1) : src_r;
    sq_pair = {16'd0, sql_r} + {16'd0, sqr_r};
    sum_add = {1'b0, sum_r} + {1'b0, sq_pair};
  end

  assign pipe_busy = (walk_left_r != '0) || rd_v_r || mul_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= ram_re;
      mul_v_r <= rd_v_r || frm_issue;
    end
    mul_sub_r <= rd_v_r && walk_sub_r;
    sql_r     <= mag_l * mag_l;
    sqr_r     <= mag_r * mag_r;
    peakc_r   <= (mag_l > mag_r) ? mag_l : mag_r;
  end

  always_comb begin
    state_nxt      = state_r;
    wr_idx_nxt     = wr_idx_r;
    fill_nxt       = fill_r;
    active_nxt     = active_r;
    active_pad_nxt = active_pad_r;
    last_valid_nxt = last_valid_r;
    last_pad_nxt   = last_pad_r;
    next_pad_nxt   = next_pad_r;
    sc_nxt         = sc_r;
    pos_nxt        = pos_r;
    peak_nxt       = peak_r;
    sum_nxt        = sum_r;
    note_nxt       = note_r;
    has_res_nxt    = has_res_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;
    walk_addr_nxt  = walk_addr_r;
    walk_left_nxt  = walk_left_r;
    walk_sub_nxt   = walk_sub_r;
    item_pop       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    frm_issue      = 1'b0;
    sc_tmp         = sc_r;

    // accumulate a squared frame, or subtract it during a trim walk
    if (mul_v_r) begin
      if (mul_sub_r) begin
        sum_nxt = (sq_pair > sum_r) ? '0 : sum_r - sq_pair;
      end else begin
        sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        if (peakc_r > peak_r) begin
          peak_nxt = peakc_r;
        end
      end
    end

    // issue ring reads during walks
    if ((state_r == ST_TRIM || state_r == ST_PRE) && walk_left_r != '0) begin
      ram_re        = 1'b1;
      walk_addr_nxt = walk_addr_r + 1'b1;
      walk_left_nxt = walk_left_r - 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (item_valid && !out_valid_r) begin
          item_pop = 1'b1;
          case (item.op)
            OP_FRAME: begin
              ram_we     = 1'b1;
              wr_idx_nxt = wr_idx_r + 1'b1;
              if (fill_r != FILL_W'(RING_FRAMES)) begin
                fill_nxt = fill_r + 1'b1;
              end
              if (active_r) begin
                if (pos_r != POS_W'(MAX_FRAMES)) begin
                  frm_issue = 1'b1;
                  pos_nxt   = pos_r + 1'b1;
                end
                state_nxt = ST_FRM_WAIT;
              end
            end
            OP_NOTE: begin
              if (go) begin
                note_nxt    = 1'b1;
                has_res_nxt = 1'b0;
                if (active_r) begin
                  // trim the newest pre-roll frames back out of the sums
                  if (!cfg.mode) begin
                    walk_left_nxt = trim[FILL_W-1:0];
                    walk_addr_nxt = wr_idx_r - trim[RING_AW-1:0];
                    pos_nxt       = pos_r - trim;
                  end
                  walk_sub_nxt = 1'b1;
                  state_nxt    = ST_TRIM;
                end else begin
                  state_nxt = ST_BEGIN;
                end
              end
            end
            OP_FINAL: begin
              if (active_r) begin
                note_nxt  = 1'b0;
                state_nxt = ST_COMMIT;
              end
            end
            OP_UNDO: begin
              if (active_r || last_valid_r) begin
                if (active_r) begin
                  active_nxt       = 1'b0;
                  next_pad_nxt     = {1'b0, active_pad_r};
                  out_res_nxt.pad  = active_pad_r;
                end else begin
                  last_valid_nxt   = 1'b0;
                  next_pad_nxt     = {1'b0, last_pad_r};
                  out_res_nxt.pad  = last_pad_r;
                end
                sc_nxt             = 1'b0;
                out_res_nxt.code   = EV_CLEARED;
                out_res_nxt.frames = '0;
                out_res_nxt.peak   = '0;
                out_res_nxt.sum    = '0;
                out_res_nxt.done   = 1'b0;
                out_valid_nxt      = 1'b1;
              end
            end
            OP_RESTART: begin
              active_nxt   = 1'b0;
              sc_nxt       = 1'b0;
              next_pad_nxt = {1'b0, cfg.start_pad};
            end
            default: begin
            end
          endcase
        end
      end
      ST_FRM_WAIT: begin
        state_nxt = ST_FRM_END;
      end
      ST_FRM_END: begin
        state_nxt = ST_IDLE;
        if (pos_r >= limit) begin
          active_nxt     = 1'b0;
          last_valid_nxt = 1'b1;
          last_pad_nxt   = active_pad_r;
          sc_tmp         = sc_r || next_pad_r[NPAD_W-1];
          sc_nxt         = sc_tmp;
          out_res_nxt    = '{code: EV_COMMIT, pad: active_pad_r, frames: pos_r,
                             peak: (pos_r != '0) ? peak_r : '0,
                             sum: sum_r[SUM_W-1] ? '1 : sum_r[OSUM_W-1:0],
                             done: sc_tmp};
          out_valid_nxt  = 1'b1;
        end
      end
      ST_TRIM: begin
        if (!pipe_busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        last_valid_nxt = 1'b1;
        last_pad_nxt   = active_pad_r;
        res_nxt        = '{code: EV_COMMIT, pad: active_pad_r, frames: pos_r,
                          peak: (pos_r != '0) ? peak_r : '0,
                          sum: sum_r[SUM_W-1] ? '1 : sum_r[OSUM_W-1:0],
                          done: sc_r};
        has_res_nxt    = 1'b1;
        if (note_r) begin
          state_nxt = ST_BEGIN;
        end else begin
          active_nxt    = 1'b0;
          out_res_nxt   = res_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_BEGIN: begin
        if (!next_pad_r[NPAD_W-1]) begin
          peak_nxt       = '0;
          sum_nxt        = '0;
          walk_left_nxt  = pre_cnt;
          walk_addr_nxt  = wr_idx_r - pre_cnt[RING_AW-1:0];
          walk_sub_nxt   = 1'b0;
          pos_nxt        = {4'd0, pre_cnt};
          active_pad_nxt = next_pad_r[PAD_W-1:0];
          state_nxt      = ST_PRE;
        end else begin
          // no pad left: end the session
          active_nxt = 1'b0;
          sc_nxt     = 1'b1;
          if (has_res_r) begin
            out_res_nxt = res_r;
          end else begin
            out_res_nxt = '{code: EV_SESSION, default: '0};
          end
          out_res_nxt.done = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_PRE: begin
        if (!pipe_busy) begin
          active_nxt   = 1'b1;
          next_pad_nxt = next_pad_r + 1'b1;
          if (has_res_r) begin
            out_res_nxt      = res_r;
            out_res_nxt.done = sc_r;
            out_valid_nxt    = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wr_idx_r     <= '0;
      fill_r       <= '0;
      active_r     <= 1'b0;
      active_pad_r <= '0;
      last_valid_r <= 1'b0;
      last_pad_r   <= '0;
      next_pad_r   <= '0;
      sc_r         <= 1'b0;
      pos_r        <= '0;
      peak_r       <= '0;
      sum_r        <= '0;
      note_r       <= 1'b0;
      has_res_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      walk_left_r  <= '0;
      walk_sub_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wr_idx_r     <= wr_idx_nxt;
      fill_r       <= fill_nxt;
      active_r     <= active_nxt;
      active_pad_r <= active_pad_nxt;
      last_valid_r <= last_valid_nxt;
      last_pad_r   <= last_pad_nxt;
      next_pad_r   <= next_pad_nxt;
      sc_r         <= sc_nxt;
      pos_r        <= pos_nxt;
      peak_r       <= peak_nxt;
      sum_r        <= sum_nxt;
      note_r       <= note_nxt;
      has_res_r    <= has_res_nxt;
      out_valid_r  <= out_valid_nxt;
      walk_left_r  <= walk_left_nxt;
      walk_sub_r   <= walk_sub_nxt;
    end
    walk_addr_r <= walk_addr_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign status    = '{active: active_r, session_complete: sc_r, next_pad: next_pad_r};

endmodule

// ----- rtl/core/preroll_slice_capture_controller.sv -----
// Pre-roll slice capture controller. An audio frame passes the frame wait and frame end states
// while a slice records; a note-on that is not ignored walks the ring frames (trim count plus
// pre-roll count, each at most 4096) through the single ring read port; finalize passes the
// commit state, undo and restart are handled in idle. The back end holds while a result waits,
// and a result appears the cycle after its item ends. A two-entry input queue accepts until full.
// Synchronous active-low reset clears control state; the ring is only read below the fill count.
module preroll_slice_capture_controller (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // left_sample[23:0], right_sample[47:24]
  input  logic [2:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // pad_index[3:0], frame_count[20:4], peak_level[44:21],
                                   // sum_squares[107:45], session_done[108], zero[111:109]
  output logic [1:0]   out_tuser,  // event_code
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  import psc_pkg::*;
  `include "preroll_slice_capture_controller_defines.svh"

  psc_cfg_t    cfg_r;
  psc_item_t   item;
  logic        item_valid, item_pop;
  psc_result_t res;
  psc_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{armed: 1'b0, mode: 1'b0, start_pad: '0, preroll: '0,
                 fixed_len: POS_W'(MAX_FRAMES)};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ARMED:     cfg_r.armed     <= cfg_data[0];
        CFG_MODE:      cfg_r.mode      <= cfg_data[0];
        CFG_START_PAD: cfg_r.start_pad <= cfg_data[PAD_W-1:0];
        CFG_PREROLL:   cfg_r.preroll   <= cfg_data[12:0];
        CFG_FIXED_LEN: cfg_r.fixed_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .in_samples (in_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  psc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res),
    .status     (status)
  );

  assign out_tuser = res.code;
  assign out_tdata = {3'd0, res.done, res.sum, res.peak, res.frames, res.pad};

  `PSC_ASSERT_NOW(a_sc_no_pad, status.session_complete, status.next_pad == NPAD_W'(PAD_COUNT), "session complete with pads left")
  `PSC_ASSERT_NOW(a_clear_not_done, out_tvalid && out_tuser == EV_CLEARED, out_tdata[108] == 1'b0, "clear result flags session done")
  `PSC_ASSERT_NOW(a_empty_peak, out_tvalid && out_tuser == EV_COMMIT && out_tdata[20:4] == '0, out_tdata[44:21] == '0, "empty slice with nonzero peak")

endmodule

// ----- bench/preroll_slice_capture_controller_tb.sv -----
// Self-checking bench for the pre-roll slice capture controller: a clocked driver and
// monitor, a bit-exact predictor of the capture state and a queue of expected results.
// Depends on psc_pkg and the controller RTL only.
module preroll_slice_capture_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam int SETTLE_CYCLES = 9000;    // longest note-on walks two 4096-frame passes
  localparam int CYCLE_LIMIT   = 20000000;
  localparam longint unsigned SUM_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]         kind;
    logic signed [23:0] l;
    logic signed [23:0] r;
  } frame_event_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [16:0]  cfg_data = '0;

  preroll_slice_capture_controller i_dut (.*);

  always #5 clk = ~clk;

  frame_event_t pending_events[$];
  frame_event_t offered;
  psc_result_t  expected_reports[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           calm = 1'b0;
  bit           hold_go = 1'b0;
  bit           hold_done = 1'b0;
  int           hold_left = 0;

  // predictor state
  logic               sh_armed, sh_mode;
  logic [3:0]         sh_start;
  logic [12:0]        sh_preroll;
  logic [16:0]        sh_fixed;
  logic signed [23:0] ring_l[RING_FRAMES], ring_r[RING_FRAMES];
  int                 ring_wr, ring_fill;
  logic signed [23:0] pad_l[int], pad_r[int];
  bit                 slice_open, last_ok;
  int                 open_pad, last_pad, next_pad;
  bit                 session_full;
  int                 rec_pos;
  longint unsigned    rec_peak, rec_sum;
  int                 pad_len[PAD_COUNT];

  function automatic longint unsigned mag(logic signed [23:0] s);
    longint signed v;
    v = s;
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned energy(logic signed [23:0] l, logic signed [23:0] r);
    return mag(l) * mag(l) + mag(r) * mag(r);
  endfunction

  function automatic void add_energy(logic signed [23:0] l, logic signed [23:0] r);
    longint unsigned sq, p;
    sq = energy(l, r);
    p = (mag(l) > mag(r)) ? mag(l) : mag(r);
    if (p > rec_peak) rec_peak = p;
    rec_sum = (rec_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : rec_sum + sq;
  endfunction

  function automatic void open_slice(int pad);
    int pre, cnt, first, ri;
    pre = (sh_preroll < RING_FRAMES) ? sh_preroll : RING_FRAMES;
    cnt = (pre < ring_fill) ? pre : ring_fill;
    first = (ring_wr + RING_FRAMES - cnt) % RING_FRAMES;
    rec_peak = 0;
    rec_sum = 0;
    pad_len[pad] = 0;
    for (int i = 0; i < cnt; i++) begin
      ri = (first + i) % RING_FRAMES;
      pad_l[pad * MAX_FRAMES + i] = ring_l[ri];
      pad_r[pad * MAX_FRAMES + i] = ring_r[ri];
      add_energy(ring_l[ri], ring_r[ri]);
    end
    rec_pos = cnt;
    open_pad = pad;
    slice_open = 1'b1;
  endfunction

  function automatic psc_result_t close_slice(int trim);
    psc_result_t res;
    longint unsigned sq;
    int n;
    n = rec_pos;
    if (trim > n) trim = n;
    for (int f = n - trim; f < n; f++) begin
      sq = energy(pad_l[open_pad * MAX_FRAMES + f], pad_r[open_pad * MAX_FRAMES + f]);
      rec_sum = (sq > rec_sum) ? 0 : rec_sum - sq;
    end
    n -= trim;
    rec_pos = n;
    pad_len[open_pad] = n;
    last_pad = open_pad;
    last_ok = 1'b1;
    res.code = EV_COMMIT;
    res.pad = 4'(open_pad);
    res.frames = 17'(n);
    res.peak = (n != 0) ? 24'(rec_peak) : '0;
    res.sum = 63'((rec_sum > SUM_SAT) ? SUM_SAT : rec_sum);
    res.done = 1'b0;
    return res;
  endfunction

  function automatic void predict_capture(frame_event_t ev);
    psc_result_t res;
    bit have, go;
    int lim, pad;
    have = 1'b0;
    res = '0;
    case (ev.kind)
      KIND_FRAME: begin
        if (slice_open) begin
          lim = MAX_FRAMES;
          if (sh_mode) begin
            lim = sh_fixed;
            if (lim < 1) lim = 1;
            if (lim > MAX_FRAMES) lim = MAX_FRAMES;
          end
          if (rec_pos < MAX_FRAMES) begin
            pad_l[open_pad * MAX_FRAMES + rec_pos] = ev.l;
            pad_r[open_pad * MAX_FRAMES + rec_pos] = ev.r;
            add_energy(ev.l, ev.r);
            rec_pos++;
          end
          if (rec_pos >= lim) begin
            res = close_slice(0);
            slice_open = 1'b0;
            if (next_pad >= PAD_COUNT) session_full = 1'b1;
            have = 1'b1;
          end
        end
        ring_l[ring_wr] = ev.l;
        ring_r[ring_wr] = ev.r;
        ring_wr = (ring_wr + 1) % RING_FRAMES;
        if (ring_fill < RING_FRAMES) ring_fill++;
      end
      KIND_NOTE: begin
        go = sh_mode ? !session_full : (slice_open || !session_full);
        if (sh_armed && go) begin
          if (slice_open) begin
            res = close_slice(sh_mode ? 0 : ((sh_preroll < RING_FRAMES) ? sh_preroll
                                                                        : RING_FRAMES));
            have = 1'b1;
          end
          if (next_pad < PAD_COUNT) begin
            open_slice(next_pad);
            next_pad++;
          end else begin
            slice_open = 1'b0;
            session_full = 1'b1;
            if (!have) begin
              res = '0;
              res.code = EV_SESSION;
              have = 1'b1;
            end
          end
        end
      end
      KIND_FINAL: begin
        if (slice_open) begin
          res = close_slice(0);
          slice_open = 1'b0;
          have = 1'b1;
        end
      end
      KIND_UNDO: begin
        if (slice_open || last_ok) begin
          if (slice_open) begin
            pad = open_pad;
            slice_open = 1'b0;
          end else begin
            pad = last_pad;
            last_ok = 1'b0;
          end
          pad_len[pad] = 0;
          next_pad = pad;
          session_full = 1'b0;
          res = '0;
          res.code = EV_CLEARED;
          res.pad = 4'(pad);
          have = 1'b1;
        end
      end
      KIND_RESTART: begin
        slice_open = 1'b0;
        session_full = 1'b0;
        next_pad = sh_start;
      end
      default: ;
    endcase
    if (have) begin
      if (res.code != EV_CLEARED) res.done = session_full;
      expected_reports.push_back(res);
    end
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    mismatches++;
  endtask

  // driver: offer queued events, predict each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_capture(offered);
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          offered = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= offered.kind;
          in_tdata <= {offered.r, offered.l};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted down on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check results and drive backpressure
  always @(posedge clk) begin
    psc_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          report("unexpected_result", out_tuser, 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_tuser != want.code) report("event_code", out_tuser, want.code);
          if (out_tdata[3:0] != want.pad) report("pad_index", out_tdata[3:0], want.pad);
          if (out_tdata[20:4] != want.frames)
            report("frame_count", out_tdata[20:4], want.frames);
          if (out_tdata[44:21] != want.peak)
            report("peak_level", out_tdata[44:21], want.peak);
          if (out_tdata[107:45] != want.sum)
            report("sum_squares", out_tdata[107:45], want.sum);
          if (out_tdata[108] != want.done) report("session_done", out_tdata[108], want.done);
        end
      end
      if ((hold_go && !hold_done) || hold_left > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ARMED:     sh_armed = val[0];
      CFG_MODE:      sh_mode = val[0];
      CFG_START_PAD: sh_start = val[3:0];
      CFG_PREROLL:   sh_preroll = val[12:0];
      CFG_FIXED_LEN: sh_fixed = val;
      default: ;
    endcase
  endtask

  task automatic setup(bit arm, bit mode, int start, int pre, int fixed_len);
    write_reg(CFG_ARMED, 17'(arm));
    write_reg(CFG_MODE, 17'(mode));
    write_reg(CFG_START_PAD, 17'(start));
    write_reg(CFG_PREROLL, 17'(pre));
    write_reg(CFG_FIXED_LEN, 17'(fixed_len));
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(7))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'sh000000;
      3: return 24'shFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic void queue_event(logic [2:0] kind);
    frame_event_t ev;
    ev.kind = kind;
    ev.l = pick_sample();
    ev.r = pick_sample();
    pending_events.push_back(ev);
  endfunction

  function automatic void queue_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_event_t ev;
    ev.kind = KIND_FRAME;
    ev.l = l;
    ev.r = r;
    pending_events.push_back(ev);
  endfunction

  // mostly note-delimited runs of frames, with stray control events mixed in
  function automatic void queue_session(int items);
    int sel, burst;
    while (items > 0) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        burst = $urandom_range(8, 1);
        repeat (burst) queue_event(KIND_FRAME);
        items -= burst;
      end else begin
        if (sel < 75) queue_event(KIND_NOTE);
        else if (sel < 82) queue_event(KIND_FINAL);
        else if (sel < 89) queue_event(KIND_UNDO);
        else if (sel < 94) queue_event(KIND_RESTART);
        else queue_event(3'($urandom_range(7, 5)));
        items--;
      end
    end
  endfunction

  initial begin
    sh_armed = 1'b0; sh_mode = 1'b0; sh_start = '0; sh_preroll = '0; sh_fixed = 17'd65536;
    foreach (ring_l[i]) begin
      ring_l[i] = '0;
      ring_r[i] = '0;
    end
    foreach (pad_len[i]) pad_len[i] = 0;
    ring_wr = 0; ring_fill = 0;
    slice_open = 0; last_ok = 0; open_pad = 0; last_pad = 0; next_pad = 0;
    session_full = 0; rec_pos = 0; rec_peak = 0; rec_sum = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // disarmed: notes ignored, nothing to finalize or undo, unknown kinds dropped
    queue_event(3'd5); queue_event(3'd6); queue_event(3'd7);
    queue_event(KIND_NOTE); queue_event(KIND_FINAL); queue_event(KIND_UNDO);
    queue_frame(24'sh800000, 24'sh7FFFFF);
    queue_frame(24'sh7FFFFF, 24'sh800000);
    queue_frame(24'shFFFFFF, 24'sh000000);
    queue_event(KIND_RESTART);
    drain();

    // sequential from the last pad: trim, run out of pads, undo, restart
    setup(1, 0, 15, 3, 65536);
    queue_event(KIND_RESTART);
    queue_event(KIND_NOTE);
    queue_frame(24'sh800000, 24'sh800000);
    queue_frame(24'sh7FFFFF, 24'sh000001);
    repeat (3) queue_event(KIND_FRAME);
    queue_event(KIND_NOTE);
    queue_event(KIND_NOTE);
    queue_event(KIND_UNDO);
    queue_event(KIND_UNDO);
    queue_event(KIND_NOTE);
    queue_event(KIND_FRAME);
    queue_event(KIND_FINAL);
    queue_event(KIND_NOTE);
    drain();

    // random sessions through several settings, one with a long output hold
    calm = 1'b1;
    setup(1, 0, 0, 0, 1);
    queue_session(90);
    drain();
    calm = 1'b0;

    setup(1, 1, 14, 8191, 0);
    queue_event(KIND_RESTART);
    hold_go = 1'b1;
    queue_session(100);
    drain();

    setup(1, 1, 3, 5, 7);
    queue_event(KIND_RESTART);
    queue_session(100);
    drain();

    setup(1, 0, 9, 4096, 131071);
    queue_event(KIND_RESTART);
    queue_session(100);
    drain();

    setup(1, 1, 0, 2, 65536);
    queue_event(KIND_RESTART);
    queue_session(70);
    drain();

    setup(0, 0, 5, 17, 3);
    queue_session(50);
    drain();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
